// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Plain invariant, checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

// ===== src/dht_pkg.sv =====
package dht_pkg;

    // Frame layout
    localparam int HUMID_BITS  = 16;
    localparam int TEMP_BITS   = 16;
    localparam int CHECK_BITS  = 8;
    localparam int TOTAL_BITS  = 40;
    localparam int STAMP_WIDTH = 16;
    localparam int COUNT_W     = 6;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_BADBIT = 2'd2;
    localparam logic [1:0] ST_BADACK = 2'd3;

    // Input function codes
    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_PIN  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_TIME = 3'd6;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WAKE,
        MODE_READ,
        MODE_READY
    } mode_t;

    typedef enum logic [1:0] {
        PH_NONE,
        PH_ACK,
        PH_FETCH
    } phase_t;

    typedef struct packed {
        logic                   func;
        logic                   pin_level;
        logic [STAMP_WIDTH-1:0] now;
    } in_word_t;

    typedef struct packed {
        logic [1:0]            status;
        logic                  data_valid;
        logic [HUMID_BITS-1:0] humidity_out;
        logic [TEMP_BITS-1:0]  temperature_out;
        logic [CHECK_BITS-1:0] check_out;
        logic                  drive_low;
    } out_word_t;

endpackage

// ===== src/dht22_single_wire_receiver.sv =====
// A word accepted at one clock edge shows its result word at the output register
// from that edge on. Throughput: one word per cycle while in_stall is low; all decoding sits
// between the state registers and the single output register.
// The input stalls only while a result word waits and the output side stalls.
// Reset (rst_n, asynchronous, active low): idle, line released, counters and shift
// registers zero, configuration at its defaults. No clearing pass is needed.
`include "assert_macros.svh"

module dht22_single_wire_receiver
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  dht_pkg::in_word_t                       in_word,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output dht_pkg::out_word_t                      out_word,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [dht_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [dht_pkg::CFG_DATA_W-1:0]          cfg_data
);

    // Configuration registers
    logic [6:0]                       tick_step_reg;
    logic [7:0]                       zero_min_reg;
    logic [7:0]                       zero_max_reg;
    logic [7:0]                       one_max_reg;
    logic [7:0]                       ack_min_reg;
    logic [7:0]                       ack_max_reg;
    logic [15:0]                      wake_time_reg;

    // Reader state
    dht_pkg::mode_t                   mode_reg, mode_next;
    dht_pkg::phase_t                  phase_reg, phase_next;
    logic [dht_pkg::STAMP_WIDTH-1:0]  stamp_reg, stamp_next;
    logic [dht_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [dht_pkg::HUMID_BITS-1:0]   humid_reg, humid_next;
    logic [dht_pkg::TEMP_BITS-1:0]    temp_reg, temp_next;
    logic [dht_pkg::CHECK_BITS-1:0]   check_reg, check_next;
    logic                             bit_error_reg, bit_error_next;
    logic                             line_low_reg, line_low_next;

    // Output register
    logic                             out_valid_reg, out_valid_next;
    dht_pkg::out_word_t               out_word_reg, out_word_next;
    dht_pkg::out_word_t               result;

    logic                             accept;
    logic [dht_pkg::STAMP_WIDTH-1:0]  elapsed;
    logic [9:0]                       t_ext;
    logic [9:0]                       step1;
    logic [9:0]                       step2;
    logic                             is_zero;
    logic                             is_one;
    logic                             ack_bad;
    logic [dht_pkg::COUNT_W-1:0]      count_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_step_reg <= 7'd1;
            zero_min_reg  <= 8'd26;
            zero_max_reg  <= 8'd28;
            one_max_reg   <= 8'd70;
            ack_min_reg   <= 8'd75;
            ack_max_reg   <= 8'd85;
            wake_time_reg <= 16'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dht_pkg::CFG_TICK_STEP: tick_step_reg <= cfg_data[6:0];
                dht_pkg::CFG_ZERO_MIN:  zero_min_reg  <= cfg_data[7:0];
                dht_pkg::CFG_ZERO_MAX:  zero_max_reg  <= cfg_data[7:0];
                dht_pkg::CFG_ONE_MAX:   one_max_reg   <= cfg_data[7:0];
                dht_pkg::CFG_ACK_MIN:   ack_min_reg   <= cfg_data[7:0];
                dht_pkg::CFG_ACK_MAX:   ack_max_reg   <= cfg_data[7:0];
                dht_pkg::CFG_WAKE_TIME: wake_time_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Timing windows; widened by the tick step, compared without going negative
    assign elapsed   = in_word.now - stamp_reg;
    assign t_ext     = {2'b00, elapsed[7:0]};
    assign step1     = {3'b000, tick_step_reg};
    assign step2     = {2'b00, tick_step_reg, 1'b0};
    assign is_zero   = ((t_ext + step2) >= {2'b00, zero_min_reg})
                    && (t_ext <= ({2'b00, zero_max_reg} + step1));
    assign is_one    = (t_ext >= step2) && (t_ext <= ({2'b00, one_max_reg} + step1));
    assign ack_bad   = ((t_ext + step1) < {2'b00, ack_min_reg})
                    || (t_ext > ({2'b00, ack_max_reg} + step1));
    assign count_inc = count_reg + 1'b1;

    // Next state
    always_comb
    begin
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        stamp_next     = stamp_reg;
        count_next     = count_reg;
        humid_next     = humid_reg;
        temp_next      = temp_reg;
        check_next     = check_reg;
        bit_error_next = bit_error_reg;
        line_low_next  = line_low_reg;
        if (in_word.func == dht_pkg::FUNC_PIN)
        begin
            if (mode_reg == dht_pkg::MODE_READ)
            begin
                stamp_next = in_word.now;
                unique case (phase_reg)
                    dht_pkg::PH_FETCH:
                    begin
                        if (!in_word.pin_level)
                        begin
                            // Falling edge ends a bit; decode by frame position
                            if (count_reg < dht_pkg::COUNT_W'(dht_pkg::TOTAL_BITS))
                            begin
                                if (!is_zero && !is_one)
                                begin
                                    bit_error_next = 1'b1;
                                end
                                else if (count_reg < dht_pkg::COUNT_W'(dht_pkg::HUMID_BITS))
                                begin
                                    humid_next = {humid_reg[dht_pkg::HUMID_BITS-2:0],
                                                  !is_zero};
                                end
                                else if (count_reg < dht_pkg::COUNT_W'(dht_pkg::HUMID_BITS
                                                                      + dht_pkg::TEMP_BITS))
                                begin
                                    temp_next = {temp_reg[dht_pkg::TEMP_BITS-2:0], !is_zero};
                                end
                                else
                                begin
                                    check_next = {check_reg[dht_pkg::CHECK_BITS-2:0],
                                                  !is_zero};
                                end
                            end
                            count_next = count_inc;
                            if (count_inc == dht_pkg::COUNT_W'(dht_pkg::TOTAL_BITS))
                            begin
                                phase_next = dht_pkg::PH_NONE;
                                mode_next  = dht_pkg::MODE_READY;
                            end
                        end
                    end
                    dht_pkg::PH_NONE:
                    begin
                        phase_next = dht_pkg::PH_ACK;
                    end
                    dht_pkg::PH_ACK:
                    begin
                        if (!ack_bad && !in_word.pin_level)
                        begin
                            phase_next     = dht_pkg::PH_FETCH;
                            count_next     = '0;
                            bit_error_next = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        else
        begin
            unique case (mode_reg)
                dht_pkg::MODE_IDLE:
                begin
                    mode_next     = dht_pkg::MODE_WAKE;
                    stamp_next    = in_word.now;
                    line_low_next = 1'b1;
                end
                dht_pkg::MODE_WAKE:
                begin
                    if (line_low_reg && (elapsed >= wake_time_reg))
                    begin
                        line_low_next = 1'b0;
                        stamp_next    = in_word.now;
                        mode_next     = dht_pkg::MODE_READ;
                        phase_next    = dht_pkg::PH_NONE;
                    end
                end
                dht_pkg::MODE_READ: ;
                dht_pkg::MODE_READY:
                begin
                    mode_next = dht_pkg::MODE_IDLE;
                end
                default: ;
            endcase
        end
    end

    // Result word
    always_comb
    begin
        result                 = '0;
        result.drive_low       = line_low_next;
        if (in_word.func == dht_pkg::FUNC_PIN)
        begin
            if (mode_reg == dht_pkg::MODE_READ)
            begin
                unique case (phase_reg)
                    dht_pkg::PH_FETCH: result.status = dht_pkg::ST_OK;
                    dht_pkg::PH_NONE:  result.status = dht_pkg::ST_OK;
                    dht_pkg::PH_ACK:   result.status = ack_bad ? dht_pkg::ST_BADACK
                                                               : dht_pkg::ST_OK;
                    default:           result.status = dht_pkg::ST_BADACK;
                endcase
            end
        end
        else if (mode_reg == dht_pkg::MODE_READY)
        begin
            result.status          = bit_error_reg ? dht_pkg::ST_BADBIT : dht_pkg::ST_OK;
            result.data_valid      = 1'b1;
            result.humidity_out    = humid_reg;
            result.temperature_out = temp_reg;
            result.check_out       = check_reg;
        end
        else
        begin
            result.status = dht_pkg::ST_BUSY;
        end
    end

    // Output register: loads on accept, empties when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_word_next  = result;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= dht_pkg::MODE_IDLE;
            phase_reg     <= dht_pkg::PH_NONE;
            stamp_reg     <= '0;
            count_reg     <= '0;
            humid_reg     <= '0;
            temp_reg      <= '0;
            check_reg     <= '0;
            bit_error_reg <= 1'b0;
            line_low_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                phase_reg     <= phase_next;
                stamp_reg     <= stamp_next;
                count_reg     <= count_next;
                humid_reg     <= humid_next;
                temp_reg      <= temp_next;
                check_reg     <= check_next;
                bit_error_reg <= bit_error_next;
                line_low_reg  <= line_low_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    // Checks
    `ASSERT_IMPL(a_deliver_idle, out_valid_reg && out_word_reg.data_valid, mode_reg == dht_pkg::MODE_IDLE, "delivered data but reader not idle")
    `ASSERT_IMPL(a_phase_in_read, phase_reg != dht_pkg::PH_NONE, mode_reg == dht_pkg::MODE_READ, "read phase active outside reading")
    `ASSERT_IMPL(a_low_in_wake, line_low_reg, mode_reg == dht_pkg::MODE_WAKE, "line held low outside wake")
    `ASSERT_IMPL(a_drive_match, out_valid_reg, out_word_reg.drive_low == line_low_reg, "pending word disagrees with line state")
    `ASSERT_ALWAYS(a_count_range, count_reg <= dht_pkg::COUNT_W'(dht_pkg::TOTAL_BITS), "bit count beyond frame length")

endmodule

// ===== bench/tb_dht22_single_wire_receiver.sv =====
`timescale 1ns / 1ps

module tb_dht22_single_wire_receiver;

    localparam int WORDS_WANTED = 1050;
    localparam int STAGE_WORDS  = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 34;

    typedef logic [dht_pkg::STAMP_WIDTH-1:0] stamp_t;
    typedef logic [dht_pkg::CFG_DATA_W-1:0]  cfg_word_t;

    // Classification of one data bit's high time
    typedef enum int {
        BIT_ZERO,
        BIT_ONE,
        BIT_BAD
    } bit_class_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                           in_valid = 1'b0;
    logic                           in_stall;
    dht_pkg::in_word_t              in_word = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    dht_pkg::out_word_t             out_word;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dht_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dht_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    dht22_single_wire_receiver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus and scoreboard storage
    dht_pkg::in_word_t  words_to_send[$];
    dht_pkg::out_word_t readings_due[$];
    int                 words_queued = 0;
    int                 words_taken  = 0;
    int                 fail_count   = 0;
    logic               in_taken     = 1'b0;

    // Pacing controls
    logic quiet      = 1'b0;
    logic hold_start = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_left  = 0;

    // Frame builder state
    stamp_t cursor = '0;
    int     frame_budget = -1;

    // Shadow configuration, reset values
    logic [6:0]  cfg_tick     = 7'd1;
    logic [7:0]  cfg_zero_min = 8'd26;
    logic [7:0]  cfg_zero_max = 8'd28;
    logic [7:0]  cfg_one_max  = 8'd70;
    logic [7:0]  cfg_ack_min  = 8'd75;
    logic [7:0]  cfg_ack_max  = 8'd85;
    logic [15:0] cfg_wake     = 16'd1000;

    // Shadow receiver state
    dht_pkg::mode_t                 rx_mode   = dht_pkg::MODE_IDLE;
    dht_pkg::phase_t                rx_phase  = dht_pkg::PH_NONE;
    stamp_t                         rx_stamp  = '0;
    logic [dht_pkg::COUNT_W-1:0]    rx_bits   = '0;
    logic [dht_pkg::HUMID_BITS-1:0] hum_sr    = '0;
    logic [dht_pkg::TEMP_BITS-1:0]  temp_sr   = '0;
    logic [dht_pkg::CHECK_BITS-1:0] chk_sr    = '0;
    logic                           bit_err   = 1'b0;
    logic                           line_held = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Decode a high time against the widened zero and one windows
    function automatic bit_class_t classify_high(int t);
        int s;
        s = int'(cfg_tick);
        if (t >= int'(cfg_zero_min) - 2 * s && t <= int'(cfg_zero_max) + s)
            return BIT_ZERO;
        if (t >= 2 * s && t <= int'(cfg_one_max) + s)
            return BIT_ONE;
        return BIT_BAD;
    endfunction

    // Pin change while reading; returns the status it causes
    function automatic logic [1:0] take_edge(logic level, stamp_t now);
        stamp_t     gap;
        int         t;
        int         s;
        bit_class_t code;
        logic [1:0] st;
        gap = now - rx_stamp;
        t   = int'(gap[7:0]);
        s   = int'(cfg_tick);
        st  = dht_pkg::ST_OK;
        case (rx_phase)
            dht_pkg::PH_FETCH:
            begin
                if (!level)
                begin
                    if (rx_bits < dht_pkg::HUMID_BITS + dht_pkg::TEMP_BITS
                                  + dht_pkg::CHECK_BITS)
                    begin
                        code = classify_high(t);
                        if (code == BIT_BAD)
                            bit_err = 1'b1;
                        else if (rx_bits < dht_pkg::HUMID_BITS)
                            hum_sr = {hum_sr[dht_pkg::HUMID_BITS-2:0], code == BIT_ONE};
                        else if (rx_bits < dht_pkg::HUMID_BITS + dht_pkg::TEMP_BITS)
                            temp_sr = {temp_sr[dht_pkg::TEMP_BITS-2:0], code == BIT_ONE};
                        else
                            chk_sr = {chk_sr[dht_pkg::CHECK_BITS-2:0], code == BIT_ONE};
                    end
                    rx_bits = rx_bits + 1'b1;
                    if (rx_bits == dht_pkg::TOTAL_BITS)
                    begin
                        rx_phase = dht_pkg::PH_NONE;
                        rx_mode  = dht_pkg::MODE_READY;
                    end
                end
            end
            dht_pkg::PH_NONE:
                rx_phase = dht_pkg::PH_ACK;
            dht_pkg::PH_ACK:
            begin
                if (t < int'(cfg_ack_min) - s || t > int'(cfg_ack_max) + s)
                    st = dht_pkg::ST_BADACK;
                else if (!level)
                begin
                    rx_phase = dht_pkg::PH_FETCH;
                    rx_bits  = '0;
                    bit_err  = 1'b0;
                end
            end
            default:
                st = dht_pkg::ST_BADACK;
        endcase
        rx_stamp = now;
        return st;
    endfunction

    // Expected result word for one accepted input word
    function automatic dht_pkg::out_word_t predict_reading(dht_pkg::in_word_t w);
        dht_pkg::out_word_t r;
        stamp_t             gap;
        r = '0;
        if (w.func == dht_pkg::FUNC_PIN)
        begin
            if (rx_mode == dht_pkg::MODE_READ)
                r.status = take_edge(w.pin_level, w.now);
        end
        else
        begin
            case (rx_mode)
                dht_pkg::MODE_IDLE:
                begin
                    rx_mode   = dht_pkg::MODE_WAKE;
                    rx_stamp  = w.now;
                    line_held = 1'b1;
                    r.status  = dht_pkg::ST_BUSY;
                end
                dht_pkg::MODE_WAKE:
                begin
                    gap = w.now - rx_stamp;
                    if (line_held && gap >= cfg_wake)
                    begin
                        line_held = 1'b0;
                        rx_stamp  = w.now;
                        rx_mode   = dht_pkg::MODE_READ;
                        rx_phase  = dht_pkg::PH_NONE;
                    end
                    r.status = dht_pkg::ST_BUSY;
                end
                dht_pkg::MODE_READ:
                    r.status = dht_pkg::ST_BUSY;
                default:
                begin
                    r.status          = bit_err ? dht_pkg::ST_BADBIT : dht_pkg::ST_OK;
                    r.data_valid      = 1'b1;
                    r.humidity_out    = hum_sr;
                    r.temperature_out = temp_sr;
                    r.check_out       = chk_sr;
                    rx_mode           = dht_pkg::MODE_IDLE;
                end
            endcase
        end
        r.drive_low = line_held;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Sender: holds a word until it is taken, idles at random
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (words_to_send.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                in_word  <= words_to_send.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_start && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Monitor: check delivered words, then predict for the word taken at this edge
    always @(posedge clk)
    begin : monitor
        dht_pkg::out_word_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (readings_due.size() == 0)
                    report_mismatch("result word with nothing due", out_word, '0);
                else
                begin
                    want = readings_due.pop_front();
                    if (out_word.status != want.status)
                        report_mismatch("status", out_word.status, want.status);
                    if (out_word.data_valid != want.data_valid)
                        report_mismatch("data_valid", out_word.data_valid, want.data_valid);
                    if (out_word.humidity_out != want.humidity_out)
                        report_mismatch("humidity_out", out_word.humidity_out,
                                        want.humidity_out);
                    if (out_word.temperature_out != want.temperature_out)
                        report_mismatch("temperature_out", out_word.temperature_out,
                                        want.temperature_out);
                    if (out_word.check_out != want.check_out)
                        report_mismatch("check_out", out_word.check_out, want.check_out);
                    if (out_word.drive_low != want.drive_low)
                        report_mismatch("drive_low", out_word.drive_low, want.drive_low);
                end
            end
            if (in_valid && !in_stall)
            begin
                in_taken = 1'b1;
                readings_due.push_back(predict_reading(in_word));
                words_taken++;
            end
        end
    end

    task automatic push_item(logic func, logic level, stamp_t now);
        dht_pkg::in_word_t w;
        w.func      = func;
        w.pin_level = level;
        w.now       = now;
        if (frame_budget != 0)
        begin
            words_to_send.push_back(w);
            words_queued++;
            if (frame_budget > 0)
                frame_budget--;
        end
    endtask

    // Advance the timestamp cursor and send a word at the new time
    task automatic step(logic func, logic level, int delta);
        cursor = cursor + stamp_t'(delta);
        push_item(func, level, cursor);
    endtask

    function automatic int pick_in(int lo, int hi);
        if (lo < 0)
            lo = 0;
        if (hi > 255)
            hi = 255;
        if (lo > hi)
            return $urandom_range(0, 255);
        return $urandom_range(lo, hi);
    endfunction

    // Wait until every queued word has been taken and answered
    task automatic wait_drained();
        @(negedge clk);
        while (words_taken != words_queued || readings_due.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Feed whatever the receiver needs to get back to idle
    task automatic recover_to_idle();
        frame_budget = -1;
        wait_drained();
        while (rx_mode != dht_pkg::MODE_IDLE)
        begin
            case (rx_mode)
                dht_pkg::MODE_WAKE:
                    push_item(dht_pkg::FUNC_POLL, 1'($urandom), rx_stamp + cfg_wake);
                dht_pkg::MODE_READ:
                begin
                    if (rx_phase == dht_pkg::PH_ACK)
                        push_item(dht_pkg::FUNC_PIN, 1'b0, rx_stamp +
                                  stamp_t'(pick_in(int'(cfg_ack_min) - int'(cfg_tick),
                                                   int'(cfg_ack_max) + int'(cfg_tick))));
                    else
                        push_item(dht_pkg::FUNC_PIN, 1'b0,
                                  rx_stamp + stamp_t'($urandom_range(0, 255)));
                end
                default:
                    push_item(dht_pkg::FUNC_POLL, 1'($urandom), stamp_t'($urandom));
            endcase
            wait_drained();
        end
    endtask

    task automatic write_reg(logic [dht_pkg::CFG_IDX_W-1:0] idx, cfg_word_t val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            dht_pkg::CFG_TICK_STEP: cfg_tick     = val[6:0];
            dht_pkg::CFG_ZERO_MIN:  cfg_zero_min = val[7:0];
            dht_pkg::CFG_ZERO_MAX:  cfg_zero_max = val[7:0];
            dht_pkg::CFG_ONE_MAX:   cfg_one_max  = val[7:0];
            dht_pkg::CFG_ACK_MIN:   cfg_ack_min  = val[7:0];
            dht_pkg::CFG_ACK_MAX:   cfg_ack_max  = val[7:0];
            dht_pkg::CFG_WAKE_TIME: cfg_wake     = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stage 0 nominal, 1 all minimum, 2 all maximum, later random
    task automatic apply_settings(int stage);
        int tick, zmin, zmax, omax, amin, amax, wake, a, b;
        case (stage)
            0:
            begin
                tick = 1; zmin = 26; zmax = 28; omax = 70; amin = 75; amax = 85; wake = 1000;
            end
            1:
            begin
                tick = 0; zmin = 0; zmax = 0; omax = 0; amin = 0; amax = 0; wake = 0;
            end
            2:
            begin
                tick = 127; zmin = 255; zmax = 255; omax = 255; amin = 255; amax = 255;
                wake = 65535;
            end
            default:
            begin
                tick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 6);
                zmin = $urandom_range(0, 80);
                zmax = zmin + $urandom_range(0, 30);
                omax = $urandom_range(zmax, 255);
                a    = $urandom_range(0, 255);
                b    = $urandom_range(0, 255);
                amin = (a < b) ? a : b;
                amax = (a < b) ? b : a;
                wake = $urandom_range(0, 3000);
            end
        endcase
        write_reg(dht_pkg::CFG_TICK_STEP, cfg_word_t'(tick));
        write_reg(dht_pkg::CFG_ZERO_MIN, cfg_word_t'(zmin));
        write_reg(dht_pkg::CFG_ZERO_MAX, cfg_word_t'(zmax));
        write_reg(dht_pkg::CFG_ONE_MAX, cfg_word_t'(omax));
        write_reg(dht_pkg::CFG_ACK_MIN, cfg_word_t'(amin));
        write_reg(dht_pkg::CFG_ACK_MAX, cfg_word_t'(amax));
        write_reg(dht_pkg::CFG_WAKE_TIME, cfg_word_t'(wake));
    endtask

    // One complete read with random content and occasional flaws
    task automatic read_frame();
        int s, lo, hi, k, roll, width, room;
        s  = int'(cfg_tick);
        lo = int'(cfg_ack_min) - s;
        hi = int'(cfg_ack_max) + s;
        cursor = stamp_t'($urandom);
        step(dht_pkg::FUNC_POLL, 1'($urandom), 0);
        // early polls and stray pin changes while the line is held
        if (cfg_wake > 0)
            repeat ($urandom_range(0, 2))
                push_item(dht_pkg::FUNC_POLL, 1'($urandom),
                          cursor + stamp_t'($urandom_range(0, cfg_wake - 1)));
        if ($urandom_range(0, 3) == 0)
            push_item(dht_pkg::FUNC_PIN, 1'($urandom), cursor + stamp_t'($urandom));
        room = 65535 - int'(cfg_wake);
        step(dht_pkg::FUNC_POLL, 1'($urandom),
             int'(cfg_wake) + $urandom_range(0, (room < 40) ? room : 40));
        if ($urandom_range(0, 3) == 0)
            push_item(dht_pkg::FUNC_POLL, 1'($urandom), cursor + stamp_t'($urandom));
        // acknowledge
        step(dht_pkg::FUNC_PIN, 1'b0, $urandom_range(10, 60));
        if ($urandom_range(0, 3) == 0)
        begin
            if (lo > 0)
                step(dht_pkg::FUNC_PIN, 1'($urandom), $urandom_range(0, lo - 1));
            else if (hi < 255)
                step(dht_pkg::FUNC_PIN, 1'($urandom), $urandom_range(hi + 1, 255));
        end
        if ($urandom_range(0, 1) == 0)
            step(dht_pkg::FUNC_PIN, 1'b1, pick_in(lo, hi));
        step(dht_pkg::FUNC_PIN, 1'b0,
             pick_in(lo, hi) + (($urandom_range(0, 9) == 0) ? 256 : 0));
        // data bits: rising edge, then falling edge carrying the high time
        for (k = 0; k < dht_pkg::TOTAL_BITS; k++)
        begin
            if ($urandom_range(0, 19) != 0)
                step(dht_pkg::FUNC_PIN, 1'b1, $urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (roll < 45)
                width = pick_in(int'(cfg_zero_min) - 2 * s, int'(cfg_zero_max) + s);
            else if (roll < 90)
                width = pick_in(2 * s, int'(cfg_one_max) + s);
            else
                width = $urandom_range(0, 255);
            if ($urandom_range(0, 19) == 0)
                width += 256 * $urandom_range(1, 3);
            step(dht_pkg::FUNC_PIN, 1'b0, width);
        end
        step(dht_pkg::FUNC_POLL, 1'($urandom), $urandom_range(0, 500));
    endtask

    // Directed opening at reset settings: ack window 74..86, zero 24..29, one 2..71
    task automatic directed_opening();
        frame_budget = -1;
        push_item(dht_pkg::FUNC_PIN, 1'b0, 16'h0000);
        push_item(dht_pkg::FUNC_PIN, 1'b1, 16'hFFFF);
        cursor = 16'hFC00;
        step(dht_pkg::FUNC_POLL, 1'b0, 0);
        push_item(dht_pkg::FUNC_POLL, 1'b1, cursor + stamp_t'(999));
        push_item(dht_pkg::FUNC_PIN, 1'b1, cursor + 16'h00F0);
        step(dht_pkg::FUNC_POLL, 1'b0, 1000);
        push_item(dht_pkg::FUNC_POLL, 1'b0, 16'h0000);
        step(dht_pkg::FUNC_PIN, 1'b0, 40);
        step(dht_pkg::FUNC_PIN, 1'b1, 40);
        step(dht_pkg::FUNC_PIN, 1'b1, 80);
        step(dht_pkg::FUNC_PIN, 1'b0, 74);
        step(dht_pkg::FUNC_PIN, 1'b1, 50);
        step(dht_pkg::FUNC_PIN, 1'b0, 24);
        step(dht_pkg::FUNC_PIN, 1'b1, 50);
        step(dht_pkg::FUNC_PIN, 1'b0, 29);
        step(dht_pkg::FUNC_PIN, 1'b1, 50);
        step(dht_pkg::FUNC_PIN, 1'b0, 71);
        step(dht_pkg::FUNC_PIN, 1'b1, 50);
        step(dht_pkg::FUNC_PIN, 1'b0, 72);
        step(dht_pkg::FUNC_PIN, 1'b1, 50);
        step(dht_pkg::FUNC_PIN, 1'b0, 256 + 70);
        push_item(dht_pkg::FUNC_POLL, 1'b1, cursor + 16'h1234);
    endtask

    initial
    begin : stimulus
        int stage, stage_end, pick, i;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_opening();
        stage = 0;
        while (words_queued < WORDS_WANTED)
        begin
            recover_to_idle();
            apply_settings(stage);
            @(posedge clk);
            quiet = (stage == 3);
            if (stage == 4)
                hold_start = 1'b1;
            stage_end = words_queued + STAGE_WORDS;
            while (words_queued < stage_end)
            begin
                recover_to_idle();
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    read_frame();
                else if (pick < 8)
                begin
                    frame_budget = $urandom_range(1, 60);
                    read_frame();
                end
                else
                    repeat ($urandom_range(1, 6))
                        push_item(1'($urandom), 1'($urandom), stamp_t'($urandom));
            end
            stage++;
        end
        quiet = 1'b0;

        // drain, then idle a while for stray words before the final checks
        for (i = 0; i < 5000 && (words_taken != words_queued || readings_due.size() != 0); i++)
            @(negedge clk);
        repeat (5) @(negedge clk);
        if (words_taken != words_queued)
            report_mismatch("input words never taken", 64'(words_taken), 64'(words_queued));
        if (readings_due.size() != 0)
            report_mismatch("result words never delivered", '0, 64'(readings_due.size()));

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/dht_pkg.sv
src/dht22_single_wire_receiver.sv
bench/tb_dht22_single_wire_receiver.sv
